@@ rtl/plpc_pkg.sv @@
// Package for the priority layer pixel compositor.
// Holds the control state type, operation and mode codes, and the blend request type.
// Used by plpc_blend and priority_layer_pixel_compositor_core.
package plpc_pkg;

	localparam int LAYER_CNT  = 6;
	localparam int POS_W      = 21;
	localparam int LAYER_W    = 40;
	localparam logic [31:0] SHADOW_COLOR = 32'h2000_0000;
	localparam logic [5:0]  ALPHA_FULL   = 6'h3F;

	localparam logic [1:0] OP_PUT_LAYER = 2'd0;
	localparam logic [1:0] OP_PUT_BACK  = 2'd1;
	localparam logic [1:0] OP_PUT_LINE  = 2'd2;
	localparam logic [1:0] OP_COMPOSE   = 2'd3;

	localparam logic [1:0] BM_TOP    = 2'd0;
	localparam logic [1:0] BM_BOTTOM = 2'd1;
	localparam logic [1:0] BM_ADD    = 2'd2;

	localparam logic [1:0] ST_MSB    = 2'd1;
	localparam logic [1:0] ST_NORMAL = 2'd2;

	localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
	localparam logic [1:0] REG_SPRITE_WINDOW = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH    = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_POS, S_EXEC, S_PICK1, S_PICK2, S_LINE, S_LWAIT,
		S_MID, S_TWAIT, S_SPR, S_FWAIT, S_DONE
	} state_t;

	typedef enum logic [1:0] {BK_MIX, BK_ADD, BK_PASS} blend_kind_t;

	typedef struct packed {
		blend_kind_t kind;
		logic [31:0] top;
		logic [31:0] bot;
		logic [7:0]  a;
		logic [5:0]  oa;
	} blend_req_t;

	function automatic blend_req_t sel_req(input logic [31:0] top, input logic [31:0] bot,
			input logic [1:0] mode);
		blend_req_t r;
		r.kind = BK_MIX;
		r.top  = top;
		r.bot  = bot;
		r.a    = {top[29:24], 2'b11};
		r.oa   = ALPHA_FULL;
		priority if (mode == BM_BOTTOM) begin
			r.kind = top[31] ? BK_MIX : BK_PASS;
			r.a    = {bot[29:24], 2'b11};
			r.oa   = top[29:24];
		end else if (mode == BM_ADD) begin
			r.kind = BK_ADD;
		end
		return r;
	endfunction

	function automatic logic is_trans(input logic [31:0] p, input logic [1:0] mode);
		logic t;
		if (mode == BM_BOTTOM || mode == BM_ADD) begin
			t = p[31];
		end else begin
			t = (p[29:24] != ALPHA_FULL);
		end
		return t;
	endfunction

endpackage

@@ rtl/plpc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module plpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/plpc_blend.sv @@
// Shared blend unit: alpha mix one product term a cycle, saturating add, or pass.
// Depends on plpc_pkg.
module plpc_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  plpc_pkg::blend_req_t req,
	output logic                 done,
	output logic [31:0]          res
);
	import plpc_pkg::*;

	blend_req_t  req_q;
	logic        busy_q;
	logic        done_q;
	logic [2:0]  k_q;
	logic [15:0] prod_s1;
	logic [7:0]  acc_q;
	logic [31:0] res_q;
	logic [2:0]  pk;
	logic [7:0]  opnd;
	logic [7:0]  wt;
	logic [31:0] scaled;
	logic [7:0]  q;
	logic [7:0]  sum;
	logic [8:0]  add_r, add_g, add_b;
	logic [7:0]  sat_r, sat_g, sat_b;

	function automatic logic [7:0] chan(input logic [31:0] p, input logic [1:0] ch);
		logic [7:0] c;
		unique case (ch)
			2'd0:    c = p[23:16];
			2'd1:    c = p[15:8];
			default: c = p[7:0];
		endcase
		return c;
	endfunction

	always_comb begin
		pk     = k_q - 3'd1;
		opnd   = k_q[0] ? chan(req_q.bot, k_q[2:1]) : chan(req_q.top, k_q[2:1]);
		wt     = k_q[0] ? ~req_q.a : req_q.a;
		scaled = {16'b0, prod_s1} * 32'h0000_8081;
		q      = scaled[30:23];
		sum    = acc_q + q;
		add_r  = {1'b0, req_q.top[23:16]} + {1'b0, req_q.bot[23:16]};
		add_g  = {1'b0, req_q.top[15:8]} + {1'b0, req_q.bot[15:8]};
		add_b  = {1'b0, req_q.top[7:0]} + {1'b0, req_q.bot[7:0]};
		sat_r  = add_r[8] ? 8'hFF : add_r[7:0];
		sat_g  = add_g[8] ? 8'hFF : add_g[7:0];
		sat_b  = add_b[8] ? 8'hFF : add_b[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				if (req_q.kind != BK_MIX || k_q == 3'd6) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q        <= req;
			res_q[31:24] <= {2'b00, req.oa};
		end else if (busy_q) begin
			unique case (req_q.kind)
				BK_PASS: res_q <= req_q.top;
				BK_ADD:  res_q <= {2'b00, ALPHA_FULL, sat_r, sat_g, sat_b};
				default: begin
					if (k_q != 3'd6) begin
						prod_s1 <= opnd * wt;
					end
					if (k_q != 3'd0) begin
						if (!pk[0]) begin
							acc_q <= q;
						end else begin
							unique case (pk[2:1])
								2'd0:    res_q[23:16] <= sum;
								2'd1:    res_q[15:8]  <= sum;
								default: res_q[7:0]   <= sum;
							endcase
						end
					end
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/priority_layer_pixel_compositor_core.sv @@
// Top level of the priority layer pixel compositor: layer, back and line stores,
// top-two layer pick and the compose sequencer. Depends on plpc_pkg, plpc_ram, plpc_blend.
//
// Channel   Direction  Items
// s_axis    in         store layer, store back, store line or compose request
// m_axis    out        composed pixel, one for each compose request
// cfg       in         register writes, no handshake
//
// After reset the layer, back and line stores are cleared; the input is not ready
// meanwhile. A compose request whose position is out of range skips the layer pick
// and the blends. Each alpha mix, add or pass runs in the shared blend unit, up to
// three blends; the mix works one product term a cycle over three channels of two
// terms. A finished pixel waits in the output register; the next request is taken
// meanwhile.
module priority_layer_pixel_compositor_core #(
	parameter int PIXELS = 262144,
	parameter int LINES  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// layer[2:0], x[12:3], y[21:13], color[53:22], priority_req[56:54],
	// line_select[58:57], shade_en[59], shade_kind[61:60], zero fill
	input  logic [63:0] s_axis_tdata,
	// op[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel[31:0]
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import plpc_pkg::*;

	localparam int PAW = $clog2(PIXELS);
	localparam int LAW = $clog2(LINES);

	state_t      state_q, state_n;
	logic [1:0]  blend_mode_q;
	logic        sprite_window_q;
	logic [10:0] line_width_q;
	logic [PAW-1:0] clr_q;

	logic [1:0]  op_q;
	logic [2:0]  layer_q;
	logic [9:0]  x_q;
	logic [8:0]  y_q;
	logic [31:0] color_q;
	logic [2:0]  prio_q;
	logic [1:0]  lsel_q;
	logic        sen_q;
	logic [1:0]  sty_q;
	logic [POS_W-1:0] pos_q;

	logic [31:0] col0_q, col1_q, linecol_q;
	logic [4:0]  tag0_q, tag1_q;
	logic [2:0]  first_q;
	logic        first_found_q;
	logic [31:0] out_q;
	logic        out_valid_q;

	logic        clearing;
	logic        pos_ok, y_ok, in_range;
	logic [PAW-1:0] lay_waddr;
	logic [LAW-1:0] line_waddr;
	logic [LAYER_W-1:0] lay_wdata;
	logic [31:0] line_wdata;
	logic        lay_we [LAYER_CNT];
	logic [LAYER_W-1:0] lay_rd [LAYER_CNT];
	logic        line_we [3];
	logic [31:0] line_rd [3];
	logic        back_we;
	logic [31:0] back_rd;
	logic        rd_en;

	logic [2:0]  pick1_idx, pick2_idx;
	logic        pick1_found, pick2_found;
	logic [2:0]  lvl_best;
	logic [31:0] col0_n, col1_n;
	logic [4:0]  tag0_n, tag1_n;
	logic [1:0]  ls_n;
	logic [1:0]  ls, st;
	logic        shadow_only;

	logic        bl_start, bl_done;
	blend_req_t  bl_req;
	logic [31:0] bl_res;

	assign clearing = (state_q == S_CLEAR);
	assign pos_ok   = pos_q < POS_W'(PIXELS);
	assign y_ok     = {1'b0, y_q} < 10'(LINES);
	assign in_range = pos_ok && y_ok;
	assign ls       = tag0_q[1:0];
	assign st       = tag0_q[4:3];
	assign shadow_only = (st == ST_MSB && col0_q[23:0] == 24'd0) || st == ST_NORMAL;

	assign lay_waddr  = clearing ? clr_q : pos_q[PAW-1:0];
	assign line_waddr = clearing ? clr_q[LAW-1:0] : y_q[LAW-1:0];
	assign lay_wdata  = clearing ? '0 : {sty_q, sen_q, lsel_q, prio_q, color_q};
	assign line_wdata = clearing ? '0 : color_q;
	assign rd_en      = (state_q == S_EXEC) && op_q == OP_COMPOSE && in_range;

	always_comb begin
		for (int l = 0; l < LAYER_CNT; l++) begin
			lay_we[l] = clearing || (state_q == S_EXEC && op_q == OP_PUT_LAYER &&
				prio_q != 3'd0 && layer_q == 3'(l) && pos_ok);
		end
		for (int n = 0; n < 3; n++) begin
			line_we[n] = (clearing && clr_q < PAW'(LINES)) || (state_q == S_EXEC &&
				op_q == OP_PUT_LINE && lsel_q == 2'(n + 1) && y_ok);
		end
		back_we = (clearing && clr_q < PAW'(LINES)) ||
			(state_q == S_EXEC && op_q == OP_PUT_BACK && y_ok);
	end

	for (genvar l = 0; l < LAYER_CNT; l++) begin : g_layer
		plpc_ram #(.WIDTH(LAYER_W), .DEPTH(PIXELS)) u_layer_ram (
			.clk(clk), .we(lay_we[l]), .waddr(lay_waddr), .wdata(lay_wdata),
			.re(rd_en), .raddr(pos_q[PAW-1:0]), .rdata(lay_rd[l])
		);
	end

	for (genvar n = 0; n < 3; n++) begin : g_line
		plpc_ram #(.WIDTH(32), .DEPTH(LINES)) u_line_ram (
			.clk(clk), .we(line_we[n]), .waddr(line_waddr), .wdata(line_wdata),
			.re(rd_en), .raddr(y_q[LAW-1:0]), .rdata(line_rd[n])
		);
	end

	plpc_ram #(.WIDTH(32), .DEPTH(LINES)) u_back_ram (
		.clk(clk), .we(back_we), .waddr(line_waddr), .wdata(line_wdata),
		.re(rd_en), .raddr(y_q[LAW-1:0]), .rdata(back_rd)
	);

	plpc_blend u_blend (
		.clk(clk), .arst_n(arst_n), .start(bl_start), .req(bl_req),
		.done(bl_done), .res(bl_res)
	);

	// Highest priority wins; on equal priority the higher layer wins.
	always_comb begin
		pick1_idx   = '0;
		pick1_found = 1'b0;
		lvl_best    = '0;
		for (int l = 0; l < LAYER_CNT; l++) begin
			if (lay_rd[l][34:32] != 3'd0 && (!pick1_found || lay_rd[l][34:32] >= lvl_best)) begin
				pick1_idx   = 3'(l);
				pick1_found = 1'b1;
				lvl_best    = lay_rd[l][34:32];
			end
		end
	end

	always_comb begin
		pick2_idx   = '0;
		pick2_found = 1'b0;
		for (int l = 0; l < LAYER_CNT; l++) begin
			if (lay_rd[l][34:32] != 3'd0 && 3'(l) != first_q &&
					(!pick2_found || lay_rd[l][34:32] >= lay_rd[pick2_idx][34:32])) begin
				pick2_idx   = 3'(l);
				pick2_found = 1'b1;
			end
		end
		if (!first_found_q) begin
			col0_n = back_rd;
			tag0_n = '0;
			col1_n = '0;
			tag1_n = '0;
		end else if (!pick2_found) begin
			col0_n = lay_rd[first_q][31:0];
			tag0_n = lay_rd[first_q][39:35];
			col1_n = back_rd;
			tag1_n = '0;
		end else begin
			col0_n = lay_rd[first_q][31:0];
			tag0_n = lay_rd[first_q][39:35];
			col1_n = lay_rd[pick2_idx][31:0];
			tag1_n = lay_rd[pick2_idx][39:35];
		end
		ls_n = tag0_n[1:0] - 2'd1;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == PAW'(PIXELS - 1)) state_n = S_IDLE;
			S_IDLE:  if (s_axis_tvalid) state_n = S_POS;
			S_POS:   state_n = S_EXEC;
			S_EXEC: begin
				if (op_q != OP_COMPOSE) state_n = S_IDLE;
				else if (in_range) state_n = S_PICK1;
				else state_n = S_DONE;
			end
			S_PICK1: state_n = S_PICK2;
			S_PICK2: state_n = S_LINE;
			S_LINE:  state_n = (ls != 2'd0) ? S_LWAIT : S_MID;
			S_LWAIT: if (bl_done) state_n = S_MID;
			S_MID: begin
				if (shadow_only) state_n = tag1_q[2] ? S_FWAIT : S_DONE;
				else if (is_trans(col0_q, blend_mode_q)) state_n = S_TWAIT;
				else state_n = S_SPR;
			end
			S_TWAIT: if (bl_done) state_n = S_SPR;
			S_SPR:   state_n = (st == ST_MSB && !sprite_window_q) ? S_FWAIT : S_DONE;
			S_FWAIT: if (bl_done) state_n = S_DONE;
			S_DONE:  if (!out_valid_q || m_axis_tready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		bl_start = 1'b0;
		bl_req   = sel_req(col0_q, col1_q, blend_mode_q);
		unique case (state_q)
			S_LINE: begin
				bl_start = (ls != 2'd0);
				bl_req   = sel_req(col0_q, linecol_q, blend_mode_q);
			end
			S_MID: begin
				if (shadow_only) begin
					bl_start = tag1_q[2];
					bl_req   = sel_req(SHADOW_COLOR, col1_q, BM_TOP);
				end else begin
					bl_start = is_trans(col0_q, blend_mode_q);
				end
			end
			S_SPR: begin
				bl_start = (st == ST_MSB && !sprite_window_q);
				bl_req   = sel_req(SHADOW_COLOR, col0_q, BM_TOP);
			end
			default: bl_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			blend_mode_q    <= BM_TOP;
			sprite_window_q <= 1'b0;
			line_width_q    <= 11'd704;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (clearing) begin
				clr_q <= clr_q + PAW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BLEND_MODE:    blend_mode_q    <= cfg_data[1:0];
					REG_SPRITE_WINDOW: sprite_window_q <= cfg_data[0];
					REG_LINE_WIDTH:    line_width_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			op_q    <= s_axis_tuser;
			layer_q <= s_axis_tdata[2:0];
			x_q     <= s_axis_tdata[12:3];
			y_q     <= s_axis_tdata[21:13];
			color_q <= s_axis_tdata[53:22];
			prio_q  <= s_axis_tdata[56:54];
			lsel_q  <= s_axis_tdata[58:57];
			sen_q   <= s_axis_tdata[59];
			sty_q   <= s_axis_tdata[61:60];
		end
		unique case (state_q)
			S_POS: pos_q <= ({12'b0, y_q} * {10'b0, line_width_q}) + {11'b0, x_q};
			S_EXEC: col0_q <= '0;
			S_PICK1: begin
				first_q       <= pick1_idx;
				first_found_q <= pick1_found;
			end
			S_PICK2: begin
				col0_q    <= col0_n;
				col1_q    <= col1_n;
				tag0_q    <= tag0_n;
				tag1_q    <= tag1_n;
				linecol_q <= line_rd[ls_n];
			end
			S_LWAIT, S_TWAIT, S_FWAIT: if (bl_done) col0_q <= bl_res;
			S_MID: if (shadow_only && !tag1_q[2]) col0_q <= col1_q;
			S_DONE: if (!out_valid_q || m_axis_tready) out_q <= col0_q;
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for priority_layer_pixel_compositor_core.
// Drives store and compose items, predicts every composed pixel and compares it.
// Depends on plpc_pkg and the compositor RTL only.
`timescale 1ns / 100ps

module tb_top;
	import plpc_pkg::*;

	localparam int PIXELS = 262144;
	localparam int LINES  = 512;

	typedef struct {
		logic [1:0]  op;
		logic [2:0]  layer;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [31:0] color;
		logic [2:0]  prio;
		logic [1:0]  lsel;
		logic        sen;
		logic [1:0]  sty;
		bit          drain;
	} pix_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	pix_item_t   pend_q[$];
	logic [31:0] pixel_q[$];
	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;
	int          send_gap = 0;
	int          stall_cnt = 0;
	bit          no_idle = 1'b0;
	int          errors = 0;
	int          n_pixels = 0;
	int          n_stores = 0;

	logic [31:0] lay_col[int];
	logic [2:0]  lay_lvl[int];
	logic [4:0]  lay_tag[int];
	logic [31:0] back_mem[LINES];
	logic [31:0] line_mem[3*LINES];
	logic [1:0]  cur_mode = BM_TOP;
	logic        cur_swin = 1'b0;
	logic [10:0] cur_width = 11'd704;

	logic [1:0]  modes[6]  = '{BM_TOP, BM_BOTTOM, BM_ADD, 2'd3, BM_BOTTOM, BM_ADD};
	logic        swins[6]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	logic [10:0] widths[6] = '{11'd704, 11'd1, 11'd1024, 11'd16, 11'd8, 11'd3};

	priority_layer_pixel_compositor_core #(.PIXELS(PIXELS), .LINES(LINES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] mix_px(logic [31:0] t, logic [31:0] b, int unsigned a,
			logic [5:0] oa);
		int unsigned ra;
		int unsigned ch[3];
		ra = 255 - a;
		for (int i = 0; i < 3; i++) begin
			ch[i] = ((t >> (8*i)) & 8'hFF) * a / 255 + ((b >> (8*i)) & 8'hFF) * ra / 255;
		end
		return {2'b00, oa, ch[2][7:0], ch[1][7:0], ch[0][7:0]};
	endfunction

	function automatic logic [31:0] over_top(logic [31:0] t, logic [31:0] b);
		return mix_px(t, b, {t[29:24], 2'b11}, 6'h3F);
	endfunction

	function automatic logic [31:0] blend_px(logic [31:0] t, logic [31:0] b);
		int unsigned s;
		logic [31:0] r;
		if (cur_mode == BM_BOTTOM) begin
			if (!t[31]) return t;
			return mix_px(t, b, {b[29:24], 2'b11}, t[29:24]);
		end
		if (cur_mode == BM_ADD) begin
			r = {2'b00, 6'h3F, 24'h0};
			for (int i = 0; i < 3; i++) begin
				s = ((t >> (8*i)) & 8'hFF) + ((b >> (8*i)) & 8'hFF);
				if (s > 255) s = 255;
				r[8*i +: 8] = s[7:0];
			end
			return r;
		end
		return over_top(t, b);
	endfunction

	function automatic bit see_through(logic [31:0] p);
		if (cur_mode == BM_BOTTOM || cur_mode == BM_ADD) return p[31];
		return p[29:24] != 6'h3F;
	endfunction

	function automatic logic [31:0] compose_px(int unsigned pos, int unsigned y);
		logic [31:0] col[2];
		logic [4:0]  tag[2];
		int          n;
		int          idx;
		logic [1:0]  ls;
		logic [1:0]  st;
		col = '{32'h0, 32'h0};
		tag = '{5'h0, 5'h0};
		n = 0;
		for (int p = 7; p > 0; p--) begin
			for (int l = LAYER_CNT - 1; l >= 0; l--) begin
				idx = l * PIXELS + pos;
				if (n < 2 && lay_lvl.exists(idx) && lay_lvl[idx] == p) begin
					col[n] = lay_col[idx];
					tag[n] = lay_tag[idx];
					n++;
				end
			end
		end
		if (n < 2) begin
			col[n] = back_mem[y];
			tag[n] = 5'h0;
		end
		ls = tag[0][1:0];
		st = tag[0][4:3];
		if (ls != 0) col[0] = blend_px(col[0], line_mem[(ls - 1) * LINES + y]);
		if (st == ST_MSB && col[0][23:0] == 24'h0) begin
			col[0] = tag[1][2] ? over_top(SHADOW_COLOR, col[1]) : col[1];
		end else if (st == ST_MSB) begin
			if (see_through(col[0])) col[0] = blend_px(col[0], col[1]);
			if (!cur_swin) col[0] = over_top(SHADOW_COLOR, col[0]);
		end else if (st == ST_NORMAL) begin
			col[0] = tag[1][2] ? over_top(SHADOW_COLOR, col[1]) : col[1];
		end else if (see_through(col[0])) begin
			col[0] = blend_px(col[0], col[1]);
		end
		return col[0];
	endfunction

	task automatic apply_item(pix_item_t it);
		int unsigned pos;
		int          idx;
		pos = it.y * cur_width + it.x;
		case (it.op)
			OP_PUT_LAYER: begin
				if (it.prio != 0 && it.layer < LAYER_CNT && pos < PIXELS) begin
					idx = it.layer * PIXELS + pos;
					lay_col[idx] = it.color;
					lay_lvl[idx] = it.prio;
					lay_tag[idx] = {it.sty, it.sen, it.lsel};
				end
				n_stores++;
			end
			OP_PUT_BACK: begin
				if (it.y < LINES) back_mem[it.y] = it.color;
				n_stores++;
			end
			OP_PUT_LINE: begin
				if (it.lsel != 0 && it.y < LINES) line_mem[(it.lsel - 1) * LINES + it.y] = it.color;
				n_stores++;
			end
			default: begin
				pixel_q.push_back((pos < PIXELS && it.y < LINES) ? compose_px(pos, it.y) : 32'h0);
			end
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		pix_item_t it;
		in_fire <= s_axis_tvalid && s_axis_tready;
		out_fire <= m_axis_tvalid && m_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			it.op = s_axis_tuser;
			{it.sty, it.sen, it.lsel, it.prio, it.color, it.y, it.x, it.layer} = s_axis_tdata[61:0];
			apply_item(it);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (pixel_q.size() == 0) begin
				report("pixel with no compose pending", m_axis_tdata, 32'h0);
			end else begin
				n_pixels++;
				if (m_axis_tdata !== pixel_q[0]) report("pixel", m_axis_tdata, pixel_q[0]);
				void'(pixel_q.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		pix_item_t it;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pend_q.size() > 0 && !(pend_q[0].drain && pixel_q.size() > 0)) begin
				it = pend_q.pop_front();
				s_axis_tuser <= it.op;
				s_axis_tdata <= {2'b00, it.sty, it.sen, it.lsel, it.prio, it.color, it.y, it.x,
					it.layer};
				s_axis_tvalid <= 1'b1;
				send_gap <= no_idle ? 0 : $urandom_range(0, 10);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				stall_cnt <= no_idle ? 0 : $urandom_range(0, 10);
				m_axis_tready <= no_idle || ($urandom_range(0, 1) == 0);
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] rand_color();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(0, 3))
			0: c[23:0] = 24'h0;
			1: c[29:24] = 6'h3F;
			default: ;
		endcase
		return c;
	endfunction

	function automatic pix_item_t make_item(logic [1:0] op, logic [2:0] layer, logic [9:0] x,
			logic [8:0] y, logic [31:0] color, logic [2:0] prio, logic [1:0] lsel, logic sen,
			logic [1:0] sty);
		pix_item_t it;
		it = '{op, layer, x, y, color, prio, lsel, sen, sty, 1'b0};
		return it;
	endfunction

	function automatic pix_item_t noise_item();
		return make_item(2'($urandom), 3'($urandom), 10'($urandom), 9'($urandom), $urandom,
			3'($urandom), 2'($urandom), 1'($urandom), 2'($urandom));
	endfunction

	task automatic add_scene();
		logic [9:0] x;
		logic [8:0] y;
		if ($urandom_range(0, 7) == 0) begin
			x = 10'($urandom);
			y = 9'($urandom);
		end else begin
			x = 10'($urandom_range(0, 3));
			y = 9'($urandom_range(0, 3));
		end
		repeat ($urandom_range(0, 4)) begin
			pend_q.push_back(make_item(OP_PUT_LAYER, 3'($urandom_range(0, 5)), x, y,
				rand_color(), 3'($urandom_range(0, 7)), 2'($urandom), 1'($urandom),
				2'($urandom)));
		end
		if ($urandom_range(0, 1)) pend_q.push_back(make_item(OP_PUT_BACK, 0, x, y, rand_color(),
			0, 0, 0, 0));
		if ($urandom_range(0, 1)) pend_q.push_back(make_item(OP_PUT_LINE, 0, x, y, rand_color(),
			0, 2'($urandom), 0, 0));
		pend_q.push_back(make_item(OP_COMPOSE, 3'($urandom), x, y, $urandom, 3'($urandom),
			2'($urandom), 1'($urandom), 2'($urandom)));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLEND_MODE:    cur_mode = val[1:0];
			REG_SPRITE_WINDOW: cur_swin = val[0];
			default:           cur_width = val;
		endcase
	endtask

	task automatic settle();
		wait (pend_q.size() == 0 && !s_axis_tvalid && pixel_q.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		pix_item_t   hold;
		for (int i = 0; i < 3*LINES; i++) line_mem[i] = 32'h0;
		for (int i = 0; i < LINES; i++) back_mem[i] = 32'h0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_BLEND_MODE, modes[ph]);
			write_reg(REG_SPRITE_WINDOW, swins[ph]);
			write_reg(REG_LINE_WIDTH, widths[ph]);
			no_idle = (ph == 2);
			if (ph == 0) begin
				pend_q.push_back(make_item(OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 0));
				pend_q.push_back(make_item(OP_PUT_LAYER, 3'd7, 1, 1, 32'hFFFF_FFFF, 7, 3, 1, 3));
				pend_q.push_back(make_item(OP_PUT_LAYER, 2, 1, 1, 32'hFFFF_FFFF, 0, 3, 1, 3));
				pend_q.push_back(make_item(OP_PUT_LAYER, 5, 1023, 511, 32'hBF12_3456, 7, 1, 1, 1));
				pend_q.push_back(make_item(OP_COMPOSE, 0, 1023, 511, 0, 0, 0, 0, 0));
				pend_q.push_back(make_item(OP_PUT_BACK, 0, 0, 511, 32'h8055_AA11, 0, 0, 0, 0));
				pend_q.push_back(make_item(OP_PUT_LINE, 0, 0, 371, 32'h3FFF_FFFF, 0, 0, 0, 0));
				pend_q.push_back(make_item(OP_PUT_LINE, 0, 0, 371, 32'h0A80_4020, 0, 3, 0, 0));
				pend_q.push_back(make_item(OP_PUT_LAYER, 5, 255, 372, 32'h0000_0000, 7, 0, 0, 1));
				pend_q.push_back(make_item(OP_PUT_LAYER, 0, 255, 372, 32'h1F80_FF00, 7, 0, 1, 0));
				pend_q.push_back(make_item(OP_COMPOSE, 0, 255, 372, 0, 0, 0, 0, 0));
				pend_q.push_back(make_item(OP_PUT_LAYER, 4, 0, 371, 32'h8000_00FF, 1, 3, 0, 2));
				pend_q.push_back(make_item(OP_PUT_LAYER, 1, 0, 371, 32'h3F01_0203, 1, 0, 1, 0));
				pend_q.push_back(make_item(OP_COMPOSE, 0, 0, 371, 0, 0, 0, 0, 0));
				pend_q.push_back(make_item(OP_PUT_LAYER, 3, 0, 371, 32'h05FF_FFFF, 6, 2, 0, 0));
				pend_q.push_back(make_item(OP_COMPOSE, 0, 0, 371, 0, 0, 0, 0, 0));
			end
			for (int k = 0; k < 25; k++) begin
				if ($urandom_range(0, 5) == 0) pend_q.push_back(noise_item());
				else add_scene();
				if (k == 12) begin
					hold = noise_item();
					hold.drain = 1'b1;
					pend_q.push_back(hold);
				end
			end
			settle();
		end
		$display("Covered %0d store items and %0d composed pixels over six register settings.",
			n_stores, n_pixels);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Run timed out with %0d pixels outstanding.", pixel_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/plpc_pkg.sv
rtl/plpc_ram.sv
rtl/plpc_blend.sv
rtl/priority_layer_pixel_compositor_core.sv
dv/tb_top.sv
